### rtl/psc_pkg.sv
// shared types and constants for the packet sequence checker
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

	localparam int MAX_PACKETS_DEF = 1048576;
	localparam int INDEX_W         = 32;
	localparam int WINDOW_W        = 16;
	localparam int UNIQUE_W        = 21;
	localparam int COUNT_W         = 32;
	localparam int HIGH_OUT_W      = 20;
	localparam int ROW_BITS        = 16;
	localparam int BIT_W           = 4;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;

	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} psc_cmd_t;

	typedef struct packed {
		logic clear_last;
	} psc_sts_t;

endpackage
`default_nettype wire

### rtl/psc_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module psc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/psc_ctrl.sv
// controller state machine: clearing pass, idle, bitmap update
`timescale 1ns / 1ps
`default_nettype none
module psc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire psc_pkg::psc_sts_t  sts,
	output logic                    busy,
	output psc_pkg::psc_cmd_t       cmd
);
	import psc_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd.clear = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.exec}))
		else $error("controller issued more than one command");

	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("update did not follow an accepted request");

endmodule
`default_nettype wire

### rtl/psc_dpath.sv
// datapath: seen bitmap, highest index, counters and result registers
`timescale 1ns / 1ps
`default_nettype none
module psc_dpath #(
	parameter int MAX_PACKETS = psc_pkg::MAX_PACKETS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire psc_pkg::psc_cmd_t             cmd,
	output psc_pkg::psc_sts_t                  sts,
	input  wire logic                          cfg_write,
	input  wire logic [psc_pkg::WINDOW_W-1:0]  cfg_data,
	input  wire logic [psc_pkg::INDEX_W-1:0]   seq_index,
	output logic                               done,
	output logic                               is_duplicate,
	output logic                               is_reordered,
	output logic                               out_of_range,
	output logic                               lost_now,
	output logic                               lost_ever,
	output logic [psc_pkg::UNIQUE_W-1:0]       unique_total,
	output logic [psc_pkg::COUNT_W-1:0]        duplicate_total,
	output logic [psc_pkg::COUNT_W-1:0]        reorder_total,
	output logic [psc_pkg::HIGH_OUT_W-1:0]     highest_seen,
	output logic [psc_pkg::HIGH_OUT_W-1:0]     missing_now
);
	import psc_pkg::*;

	localparam int IDX_W = $clog2(MAX_PACKETS);
	localparam int ROWS  = (MAX_PACKETS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SUM_W = ((IDX_W > UNIQUE_W + 1) ? IDX_W : UNIQUE_W + 1) + 1;
	localparam int HW    = (IDX_W > HIGH_OUT_W) ? IDX_W : HIGH_OUT_W;

	logic [WINDOW_W-1:0] window_q;
	logic [IDX_W-1:0]    idx_q;
	logic                oor_q;
	logic [IDX_W-1:0]    high_q;
	logic [UNIQUE_W-1:0] unique_q;
	logic [COUNT_W-1:0]  dup_cnt_q;
	logic [COUNT_W-1:0]  reord_cnt_q;
	logic                ever_q;
	logic                done_q;
	logic                dup_q;
	logic                reord_q;
	logic                oor_out_q;
	logic                lost_q;
	logic [ROW_W-1:0]    clr_q;

	logic [ROW_BITS-1:0] rdata;
	logic [ROW_BITS-1:0] wdata;
	logic [ROW_BITS-1:0] bit_mask;
	logic [ROW_W-1:0]    raddr;
	logic [ROW_W-1:0]    waddr;
	logic                we;
	logic                hit;
	logic                reord;
	logic [IDX_W-1:0]    high_n;
	logic [IDX_W-1:0]    high_l;
	logic                lost;
	logic [SUM_W-1:0]    limit;
	logic [SUM_W-1:0]    high_ext;
	logic [SUM_W-1:0]    uniq_ext;
	logic [SUM_W-1:0]    diff;
	logic [HW-1:0]       high_wide;

	// bitmap row access
	assign raddr    = ROW_W'(seq_index >> BIT_W);
	assign bit_mask = ROW_BITS'(1) << idx_q[BIT_W-1:0];
	assign hit      = |(rdata & bit_mask);
	assign we       = cmd.clear | (cmd.exec & ~oor_q);
	assign waddr    = cmd.clear ? clr_q : ROW_W'(idx_q >> BIT_W);
	assign wdata    = cmd.clear ? '0 : (rdata | bit_mask);

	psc_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS)
	) u_seen_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.clear_last = (clr_q == ROW_W'(ROWS - 1));

	// update logic
	assign reord  = (idx_q < high_q);
	assign high_n = (idx_q > high_q) ? idx_q : high_q;
	assign high_l = oor_q ? high_q : high_n;
	assign limit  = SUM_W'(unique_q) + SUM_W'(window_q);
	assign lost   = (SUM_W'(high_l) > limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			clr_q       <= '0;
			done_q      <= 1'b0;
			high_q      <= '0;
			unique_q    <= '0;
			dup_cnt_q   <= '0;
			reord_cnt_q <= '0;
			ever_q      <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cfg_write) begin
				window_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + ROW_W'(1);
			end
			if (cmd.exec && !oor_q) begin
				high_q <= high_n;
				if (lost) begin
					ever_q <= 1'b1;
				end
				if (reord && (reord_cnt_q != '1)) begin
					reord_cnt_q <= reord_cnt_q + COUNT_W'(1);
				end
				if (hit) begin
					if (dup_cnt_q != '1) begin
						dup_cnt_q <= dup_cnt_q + COUNT_W'(1);
					end
				end else if (unique_q != '1) begin
					unique_q <= unique_q + UNIQUE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= seq_index[IDX_W-1:0];
			oor_q <= (seq_index >= INDEX_W'(MAX_PACKETS));
		end
		if (cmd.exec) begin
			dup_q     <= ~oor_q & hit;
			reord_q   <= ~oor_q & reord;
			oor_out_q <= oor_q;
			lost_q    <= lost;
		end
	end

	// results
	assign high_ext  = SUM_W'(high_q);
	assign uniq_ext  = SUM_W'(unique_q);
	assign diff      = high_ext - uniq_ext;
	assign high_wide = HW'(high_q);

	assign done            = done_q;
	assign is_duplicate    = dup_q;
	assign is_reordered    = reord_q;
	assign out_of_range    = oor_out_q;
	assign lost_now        = lost_q;
	assign lost_ever       = ever_q;
	assign unique_total    = unique_q;
	assign duplicate_total = dup_cnt_q;
	assign reorder_total   = reord_cnt_q;
	assign highest_seen    = high_wide[HIGH_OUT_W-1:0];
	assign missing_now     = (high_ext > uniq_ext) ? diff[HIGH_OUT_W-1:0] : '0;

	a_oor_keeps_high: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && oor_out_q) |-> $stable(high_q))
		else $error("out of range request changed highest index");

	a_unique_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		unique_q >= $past(unique_q))
		else $error("unique count decreased");

	a_dup_keeps_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dup_q) |-> $stable(unique_q))
		else $error("duplicate changed unique count");

endmodule
`default_nettype wire

### rtl/packet_sequence_checker.sv
// top level of the packet sequence checker
`timescale 1ns / 1ps
`default_nettype none
// Each request carries one packet index: first the seen-bitmap row (16 bits
// per row) is read from the memory, then the counters are updated and the row
// is written back; busy is high during the update cycle, so no new request is
// accepted while an update is in progress. The result appears in the cycle
// after the update, on the result ports with done high for exactly one cycle;
// there is no way to hold it off, so it must be captured then. After reset
// the bitmap is cleared one row per cycle, ceil(MAX_PACKETS/16) rows (65536
// at the default size), with busy high. The window register may be written
// whenever no request is in flight, the clearing pass included.
module packet_sequence_checker #(
	parameter int MAX_PACKETS = psc_pkg::MAX_PACKETS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cfg_write,
	input  wire logic [psc_pkg::WINDOW_W-1:0]  cfg_data,
	input  wire logic [psc_pkg::INDEX_W-1:0]   seq_index,
	output logic                               done,
	output logic                               is_duplicate,
	output logic                               is_reordered,
	output logic                               out_of_range,
	output logic                               lost_now,
	output logic                               lost_ever,
	output logic [psc_pkg::UNIQUE_W-1:0]       unique_total,
	output logic [psc_pkg::COUNT_W-1:0]        duplicate_total,
	output logic [psc_pkg::COUNT_W-1:0]        reorder_total,
	output logic [psc_pkg::HIGH_OUT_W-1:0]     highest_seen,
	output logic [psc_pkg::HIGH_OUT_W-1:0]     missing_now
);
	import psc_pkg::*;

	psc_cmd_t cmd;
	psc_sts_t sts;

	psc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	psc_dpath #(
		.MAX_PACKETS (MAX_PACKETS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.seq_index       (seq_index),
		.done            (done),
		.is_duplicate    (is_duplicate),
		.is_reordered    (is_reordered),
		.out_of_range    (out_of_range),
		.lost_now        (lost_now),
		.lost_ever       (lost_ever),
		.unique_total    (unique_total),
		.duplicate_total (duplicate_total),
		.reorder_total   (reorder_total),
		.highest_seen    (highest_seen),
		.missing_now     (missing_now)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

endmodule
`default_nettype wire
